/* rtl/vfr_pkg.sv */
package vfr_pkg;

    localparam int PIECE_BYTES = 1024;
    localparam int PIECE_AW = $clog2(PIECE_BYTES);
    localparam int MAX_FRAME_BYTES = 65536;
    localparam int FRAME_AW = $clog2(MAX_FRAME_BYTES);
    localparam int PIECE_SLOTS = (MAX_FRAME_BYTES + PIECE_BYTES - 1) / PIECE_BYTES;
    localparam int SLOT_AW = $clog2(PIECE_SLOTS);
    localparam int PREFIX_LEN = 10;
    localparam int AUDIO_HEADER_BYTES = 13;
    localparam int VIDEO_HEADER_BYTES = 25;
    localparam int HDR_END = PREFIX_LEN + VIDEO_HEADER_BYTES;
    localparam int POS_MAX = HDR_END + PIECE_BYTES;
    localparam int POS_W = 11;

    localparam logic [31:0] TAG_WORD = 32'h5044_5356;
    localparam logic [31:0] NEWER_LIMIT = 32'h8000_0000;

    localparam logic [2:0] CFG_HOST_ADDR = 3'd0;
    localparam logic [2:0] CFG_HOST_PORT = 3'd1;
    localparam logic [2:0] CFG_VERSION = 3'd2;
    localparam logic [2:0] CFG_NONCE = 3'd3;

    localparam logic [2:0] STAT_REJECT = 3'd0;
    localparam logic [2:0] STAT_STORED = 3'd1;
    localparam logic [2:0] STAT_DUP = 3'd2;
    localparam logic [2:0] STAT_DONE = 3'd3;
    localparam logic [2:0] STAT_READ = 3'd4;

    typedef struct packed {
        logic             bad;
        logic [POS_W-1:0] len;
        logic [31:0]      seq;
        logic [15:0]      frag;
        logic [15:0]      frags;
        logic [31:0]      flen;
    } pkt_info_t;

endpackage

/* rtl/vfr_ram.sv */
module vfr_ram #(
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/vfr_parser.sv */
module vfr_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic [31:0]           host_addr,
    input  logic [15:0]           host_port,
    input  logic [7:0]            version_byte,
    input  logic [63:0]           session_nonce,
    output vfr_pkg::pkt_info_t    info,
    output logic                  stage_we,
    output logic [vfr_pkg::PIECE_AW-1:0] stage_addr,
    output logic [7:0]            stage_data
);

    logic [vfr_pkg::POS_W-1:0] pos_reg;
    logic                      bad_reg;
    logic [31:0]               hf0_reg, hf1_reg, hf2_reg;
    logic                      done_bad_reg;
    logic [vfr_pkg::POS_W-1:0] len_reg;
    logic [7:0]                exp_byte;
    logic                      chk;
    logic                      byte_bad;
    logic [vfr_pkg::POS_W-1:0] pay_off;

    always_comb
    begin
        exp_byte = 8'd0;
        chk = 1'b1;
        unique case (pos_reg)
            11'd0, 11'd1, 11'd2: exp_byte = 8'd0;
            11'd3: exp_byte = 8'd1;
            11'd4: exp_byte = host_addr[31:24];
            11'd5: exp_byte = host_addr[23:16];
            11'd6: exp_byte = host_addr[15:8];
            11'd7: exp_byte = host_addr[7:0];
            11'd8: exp_byte = host_port[15:8];
            11'd9: exp_byte = host_port[7:0];
            11'd10: exp_byte = vfr_pkg::TAG_WORD[31:24];
            11'd11: exp_byte = vfr_pkg::TAG_WORD[23:16];
            11'd12: exp_byte = vfr_pkg::TAG_WORD[15:8];
            11'd13: exp_byte = vfr_pkg::TAG_WORD[7:0];
            11'd14: exp_byte = version_byte;
            11'd15: exp_byte = session_nonce[63:56];
            11'd16: exp_byte = session_nonce[55:48];
            11'd17: exp_byte = session_nonce[47:40];
            11'd18: exp_byte = session_nonce[39:32];
            11'd19: exp_byte = session_nonce[31:24];
            11'd20: exp_byte = session_nonce[23:16];
            11'd21: exp_byte = session_nonce[15:8];
            11'd22: exp_byte = session_nonce[7:0];
            default: chk = 1'b0;
        endcase
    end

    assign pay_off = pos_reg - vfr_pkg::POS_W'(vfr_pkg::HDR_END);
    // payload past one piece marks the packet bad
    assign byte_bad = (chk && (data_byte != exp_byte))
                    || (pos_reg >= vfr_pkg::POS_W'(vfr_pkg::POS_MAX));

    assign stage_we = en && (pos_reg >= vfr_pkg::POS_W'(vfr_pkg::HDR_END))
                    && (pos_reg < vfr_pkg::POS_W'(vfr_pkg::POS_MAX));
    assign stage_addr = pay_off[vfr_pkg::PIECE_AW-1:0];
    assign stage_data = data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            bad_reg <= 1'b0;
            hf0_reg <= '0;
            hf1_reg <= '0;
            hf2_reg <= '0;
            done_bad_reg <= 1'b0;
            len_reg <= '0;
        end
        else if (en)
        begin
            if (pos_reg >= 11'd23 && pos_reg < 11'd27)
            begin
                hf0_reg <= {hf0_reg[23:0], data_byte};
            end
            else if (pos_reg >= 11'd27 && pos_reg < 11'd31)
            begin
                hf1_reg <= {hf1_reg[23:0], data_byte};
            end
            else if (pos_reg >= 11'd31 && pos_reg < vfr_pkg::POS_W'(vfr_pkg::HDR_END))
            begin
                hf2_reg <= {hf2_reg[23:0], data_byte};
            end
            if (last_byte)
            begin
                pos_reg <= '0;
                bad_reg <= 1'b0;
                done_bad_reg <= bad_reg || byte_bad;
                len_reg <= pos_reg + 11'd1;
            end
            else
            begin
                bad_reg <= bad_reg || byte_bad;
                if (pos_reg < vfr_pkg::POS_W'(vfr_pkg::POS_MAX))
                begin
                    pos_reg <= pos_reg + 11'd1;
                end
            end
        end
    end

    assign info.bad = done_bad_reg;
    assign info.len = len_reg;
    assign info.seq = hf0_reg;
    assign info.frag = hf1_reg[31:16];
    assign info.frags = hf1_reg[15:0];
    assign info.flen = hf2_reg;

endmodule

/* rtl/video_fragment_reassembler.sv */
// channel   dir  signals                       item
// s_*       in   tvalid tready tdata tlast tuser  packet byte or store read
// m_*       out  tvalid tready tdata           status and frame state
// cfg_*     in   we index data                 register write
//
// a packet byte that is not the last leaves the block idle; a last byte leads to the check,
// and an accepted piece is then copied from the staging store into the frame store
// a read goes through the registered frame store read port
// reset clears all control state and the fragment bitmap; the stores are not cleared
// a waiting result holds the check or read until m_tready frees the output register
module video_fragment_reassembler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], read_address[23:8]
    input  logic        s_tlast,
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], frame_sequence[34:3], frame_bytes[51:35], pieces_held[58:52],
    // link_seen[59], read_data[67:60], zero fill[71:68]
    output logic [71:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_RD, S_COPY} state_t;

    state_t state_reg;
    logic [31:0] host_addr_reg;
    logic [15:0] host_port_reg;
    logic [7:0]  version_reg;
    logic [63:0] nonce_reg;

    logic [31:0] cur_seq_reg;
    logic        seq_valid_reg;
    logic        asm_reg;
    logic [16:0] cur_len_reg;
    logic [6:0]  total_reg;
    logic [6:0]  count_reg;
    logic        seen_reg;
    logic [vfr_pkg::PIECE_SLOTS-1:0] bitmap_reg;

    logic        m_valid_reg;
    logic [71:0] m_data_reg;

    logic [vfr_pkg::SLOT_AW-1:0] frag_reg;
    logic [10:0] plen_reg;
    logic [10:0] cnt_reg;
    logic        pend_reg;
    logic [vfr_pkg::FRAME_AW-1:0] pend_addr_reg;

    vfr_pkg::pkt_info_t info;
    logic        accept;
    logic        byte_en;
    logic        stage_we;
    logic [vfr_pkg::PIECE_AW-1:0] stage_waddr;
    logic [7:0]  stage_wdata;
    logic [7:0]  stage_rdata;
    logic [7:0]  frame_rdata;
    logic        out_free;
    logic        out_fire;

    logic [16:0] flen17;
    logic [6:0]  ceil_pieces;
    logic [16:0] rem;
    logic [10:0] plen;
    logic        fmt_ok;
    logic [31:0] seq_diff;
    logic        restart;
    logic        mismatch;
    logic        dup;
    logic [6:0]  count_new;
    logic [6:0]  total_new;
    logic        commit;
    logic        full_now;
    logic [2:0]  status_chk;
    logic [31:0] seq_out;
    logic [16:0] len_out;
    logic [6:0]  count_out;
    logic [vfr_pkg::PIECE_SLOTS-1:0] bitmap_next;

    assign accept = s_tvalid && s_tready;
    assign byte_en = accept && !s_tuser;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign out_fire = ((state_reg == S_RD) || (state_reg == S_CHECK)) && out_free;

    vfr_parser u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .en(byte_en),
        .data_byte(s_tdata[7:0]),
        .last_byte(s_tlast),
        .host_addr(host_addr_reg),
        .host_port(host_port_reg),
        .version_byte(version_reg),
        .session_nonce(nonce_reg),
        .info(info),
        .stage_we(stage_we),
        .stage_addr(stage_waddr),
        .stage_data(stage_wdata)
    );

    vfr_ram #(.AW(vfr_pkg::PIECE_AW), .DW(8)) u_stage (
        .clk(clk),
        .we(stage_we),
        .waddr(stage_waddr),
        .wdata(stage_wdata),
        .re(state_reg == S_COPY),
        .raddr(cnt_reg[vfr_pkg::PIECE_AW-1:0]),
        .rdata(stage_rdata)
    );

    vfr_ram #(.AW(vfr_pkg::FRAME_AW), .DW(8)) u_frame (
        .clk(clk),
        .we(pend_reg),
        .waddr(pend_addr_reg),
        .wdata(stage_rdata),
        .re(accept && s_tuser),
        .raddr(s_tdata[23:8]),
        .rdata(frame_rdata)
    );

    // packet format, fragment geometry, sequence tracking and check status
    always_comb
    begin
        flen17 = info.flen[16:0];
        ceil_pieces = 7'(({1'b0, flen17} + 18'(vfr_pkg::PIECE_BYTES - 1))
                         >> vfr_pkg::PIECE_AW);
        rem = flen17 - {1'b0, info.frag[vfr_pkg::SLOT_AW-1:0],
                        {vfr_pkg::PIECE_AW{1'b0}}};
        plen = (rem > 17'(vfr_pkg::PIECE_BYTES)) ? 11'(vfr_pkg::PIECE_BYTES) : rem[10:0];
        fmt_ok = !info.bad
              && (info.len >= 11'(vfr_pkg::PREFIX_LEN + vfr_pkg::AUDIO_HEADER_BYTES))
              && (info.len >= 11'(vfr_pkg::HDR_END))
              && (info.flen != 32'd0)
              && (info.flen <= 32'(vfr_pkg::MAX_FRAME_BYTES))
              && (info.frags != 16'd0)
              && (info.frag < info.frags)
              && (info.frags == {9'd0, ceil_pieces})
              && (info.len == 11'(vfr_pkg::HDR_END) + plen);
        seq_diff = info.seq - cur_seq_reg;
        restart = !seq_valid_reg
               || ((info.seq != cur_seq_reg) && (seq_diff < vfr_pkg::NEWER_LIMIT));
        mismatch = !restart && ((info.seq != cur_seq_reg) || !asm_reg
                  || (cur_len_reg != flen17) || (total_reg != info.frags[6:0]));
        dup = !restart && bitmap_reg[info.frag[vfr_pkg::SLOT_AW-1:0]];
        count_new = (restart ? 7'd0 : count_reg) + 7'd1;
        total_new = restart ? info.frags[6:0] : total_reg;
        commit = fmt_ok && !mismatch && !dup;
        full_now = (count_new == total_new);
        priority if (!fmt_ok || mismatch)
            status_chk = vfr_pkg::STAT_REJECT;
        else if (dup)
            status_chk = vfr_pkg::STAT_DUP;
        else if (full_now)
            status_chk = vfr_pkg::STAT_DONE;
        else
            status_chk = vfr_pkg::STAT_STORED;
        seq_out = (fmt_ok && restart) ? info.seq : cur_seq_reg;
        len_out = (fmt_ok && restart) ? flen17 : cur_len_reg;
        count_out = commit ? count_new : count_reg;
        // a restart drops the old pieces before the new one is marked
        bitmap_next = restart ? '0 : bitmap_reg;
        bitmap_next[info.frag[vfr_pkg::SLOT_AW-1:0]] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_addr_reg <= '0;
            host_port_reg <= '0;
            version_reg <= '0;
            nonce_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vfr_pkg::CFG_HOST_ADDR: host_addr_reg <= cfg_data[31:0];
                vfr_pkg::CFG_HOST_PORT: host_port_reg <= cfg_data[15:0];
                vfr_pkg::CFG_VERSION: version_reg <= cfg_data[7:0];
                vfr_pkg::CFG_NONCE: nonce_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_seq_reg <= '0;
            seq_valid_reg <= 1'b0;
            asm_reg <= 1'b0;
            cur_len_reg <= '0;
            total_reg <= '0;
            count_reg <= '0;
            seen_reg <= 1'b0;
            bitmap_reg <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg <= '0;
            frag_reg <= '0;
            plen_reg <= '0;
            cnt_reg <= '0;
            pend_reg <= 1'b0;
            pend_addr_reg <= '0;
        end
        else
        begin
            if (out_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && s_tuser)
                    begin
                        state_reg <= S_RD;
                    end
                    else if (accept && s_tlast)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_RD:
                begin
                    if (out_free)
                    begin
                        m_data_reg <= {4'd0, frame_rdata, seen_reg, count_reg, cur_len_reg,
                                       cur_seq_reg, vfr_pkg::STAT_READ};
                        state_reg <= S_IDLE;
                    end
                end
                S_CHECK:
                begin
                    if (out_free)
                    begin
                        m_data_reg <= {4'd0, 8'd0, seen_reg || fmt_ok, count_out, len_out,
                                       seq_out, status_chk};
                        if (fmt_ok)
                        begin
                            seen_reg <= 1'b1;
                            if (restart)
                            begin
                                cur_seq_reg <= info.seq;
                                cur_len_reg <= flen17;
                                total_reg <= info.frags[6:0];
                                seq_valid_reg <= 1'b1;
                            end
                        end
                        if (commit)
                        begin
                            bitmap_reg <= bitmap_next;
                            count_reg <= count_new;
                            asm_reg <= !full_now;
                            frag_reg <= info.frag[vfr_pkg::SLOT_AW-1:0];
                            plen_reg <= plen;
                            cnt_reg <= '0;
                            state_reg <= S_COPY;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_COPY:
                begin
                    // staging read issued here, frame write lands in the following cycle
                    if (cnt_reg < plen_reg)
                    begin
                        pend_reg <= 1'b1;
                        pend_addr_reg <= {frag_reg, cnt_reg[vfr_pkg::PIECE_AW-1:0]};
                        cnt_reg <= cnt_reg + 11'd1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

`ifndef SYNTHESIS
    a_count_bitmap: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(bitmap_reg) == 32'(count_reg))
        else $error("piece count disagrees with bitmap");
    a_count_total: assert property (@(posedge clk) disable iff (!rst_n)
        asm_reg |-> (count_reg < total_reg))
        else $error("assembling with all pieces held");
    a_write_copy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_COPY))
        else $error("frame store write outside copy");
`endif

endmodule
